// ===== hdl/ehx_pkg.sv =====
package ehx_pkg;

    localparam int CNT_W = 16;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [15:0] ETYPE_ARP  = 16'h0806;
    localparam logic [15:0] ETYPE_IPV6 = 16'h86DD;

    localparam logic [7:0] PROTO_ICMP  = 8'd1;
    localparam logic [7:0] PROTO_TCP   = 8'd6;
    localparam logic [7:0] PROTO_UDP   = 8'd17;
    localparam logic [7:0] PROTO_ICMP6 = 8'd58;

    localparam logic [2:0] KIND_TCP   = 3'd0;
    localparam logic [2:0] KIND_UDP   = 3'd1;
    localparam logic [2:0] KIND_ICMP  = 3'd2;
    localparam logic [2:0] KIND_ARP   = 3'd3;
    localparam logic [2:0] KIND_OTHER = 3'd4;
    localparam logic [2:0] KIND_TRUNC = 3'd5;

    localparam logic [3:0] TAG_DST_MAC   = 4'd0;
    localparam logic [3:0] TAG_SRC_MAC   = 4'd1;
    localparam logic [3:0] TAG_LENGTH    = 4'd2;
    localparam logic [3:0] TAG_SRC_IP_HI = 4'd3;
    localparam logic [3:0] TAG_SRC_IP_LO = 4'd4;
    localparam logic [3:0] TAG_DST_IP_HI = 4'd5;
    localparam logic [3:0] TAG_DST_IP_LO = 4'd6;
    localparam logic [3:0] TAG_PORTS     = 4'd7;
    localparam logic [3:0] TAG_ICMP      = 4'd8;
    localparam logic [3:0] TAG_ARP_FIXED = 4'd9;
    localparam logic [3:0] TAG_ARP_SHA   = 4'd10;
    localparam logic [3:0] TAG_ARP_SPA   = 4'd11;
    localparam logic [3:0] TAG_ARP_THA   = 4'd12;
    localparam logic [3:0] TAG_ARP_TPA   = 4'd13;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       end_of_frame;
    } byte_t;

    typedef struct packed {
        logic [2:0]  frame_kind;
        logic        over_ipv6;
        logic [3:0]  field_tag;
        logic [63:0] field_value;
        logic        last_record;
    } record_t;

    typedef struct packed {
        logic [2:0]       kind;
        logic             v6;
        logic [CNT_W-1:0] length;
        logic [1:0][47:0] mac;
        logic [3:0][63:0] addr;
        logic [31:0]      l4;
        logic [63:0]      arp_fixed;
        logic [1:0][47:0] arp_hw;
        logic [1:0][31:0] arp_ip;
    } summary_t;

    function automatic logic [3:0] rec_tag(input logic [2:0] kind, input logic [2:0] idx);
        logic [3:0] tag;
        tag = {1'b0, idx};
        if (kind == KIND_ARP && idx >= 3'd3) begin
            tag = 4'd6 + {1'b0, idx};
        end
        else if (kind != KIND_ARP && idx == 3'd7) begin
            tag = (kind == KIND_ICMP) ? TAG_ICMP : TAG_PORTS;
        end
        return tag;
    endfunction

    function automatic logic rec_last(input logic [2:0] kind, input logic [2:0] idx);
        logic last;
        if (kind == KIND_TRUNC) begin
            last = (idx == 3'd2);
        end
        else if (kind == KIND_OTHER) begin
            last = (idx == 3'd6);
        end
        else begin
            last = (idx == 3'd7);
        end
        return last;
    endfunction

endpackage

// ===== hdl/ehx_front.sv =====
module ehx_front
    import ehx_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = 65535
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     accept,
    input  byte_t    item,
    output logic     push,
    output summary_t summary
);

    localparam int CW = $clog2(MAX_FRAME_BYTES + 1);
    localparam int PW = ((CW > 8) ? CW : 8) + 1;
    localparam logic [CW-1:0] MAX_COUNT = CW'(MAX_FRAME_BYTES);

    logic [CW-1:0]    count_reg, count_next;
    logic [15:0]      ether_reg, ether_next;
    logic [7:0]       l4off_reg, l4off_next;
    logic [7:0]       proto_reg, proto_next;
    logic [1:0][47:0] mac_reg, mac_next;
    logic [3:0][63:0] addr_reg, addr_next;
    logic [31:0]      l4_reg, l4_next;
    logic [63:0]      arpfix_reg, arpfix_next;
    logic [1:0][47:0] arphw_reg, arphw_next;
    logic [1:0][31:0] arpip_reg, arpip_next;

    logic [CW-1:0] pos;
    logic [7:0]    b;
    logic          is_arp;
    logic          is_v6;
    logic [PW-1:0] pos_w;
    logic [PW-1:0] off_w;
    logic [PW-1:0] rel_l4;
    logic [5:0]    rel_v6;
    logic          known;
    logic [8:0]    need;
    logic [8:0]    extra;
    logic [8:0]    l4_end;
    logic [2:0]    kind;

    always_comb
    begin
        pos         = count_reg;
        b           = item.frame_byte;
        count_next  = (count_reg < MAX_COUNT) ? count_reg + CW'(1) : count_reg;
        ether_next  = ether_reg;
        l4off_next  = l4off_reg;
        proto_next  = proto_reg;
        mac_next    = mac_reg;
        addr_next   = addr_reg;
        l4_next     = l4_reg;
        arpfix_next = arpfix_reg;
        arphw_next  = arphw_reg;
        arpip_next  = arpip_reg;
        is_arp      = (ether_reg == ETYPE_ARP);
        is_v6       = (ether_reg == ETYPE_IPV6);
        rel_v6      = 6'(pos) - 6'd22;
        pos_w       = PW'(pos);
        off_w       = '0;
        rel_l4      = '0;
        if (pos < CW'(6)) begin
            mac_next[0][8 * (3'd5 - pos[2:0]) +: 8] = b;
        end
        else if (pos < CW'(12)) begin
            mac_next[1][8 * (4'd11 - pos[3:0]) +: 8] = b;
        end
        else if (pos < CW'(14)) begin
            if (pos[0]) begin
                ether_next[7:0] = b;
            end
            else begin
                ether_next[15:8] = b;
            end
        end
        else if (is_arp) begin
            if (pos < CW'(22)) begin
                arpfix_next[8 * (5'd21 - pos[4:0]) +: 8] = b;
            end
            else if (pos < CW'(28)) begin
                arphw_next[0][8 * (5'd27 - pos[4:0]) +: 8] = b;
            end
            else if (pos < CW'(32)) begin
                arpip_next[0][8 * (5'd31 - pos[4:0]) +: 8] = b;
            end
            else if (pos < CW'(38)) begin
                arphw_next[1][8 * (6'd37 - pos[5:0]) +: 8] = b;
            end
            else if (pos < CW'(42)) begin
                arpip_next[1][8 * (6'd41 - pos[5:0]) +: 8] = b;
            end
        end
        else begin
            if (pos == CW'(14)) begin
                l4off_next = is_v6 ? 8'd54 : 8'd14 + {2'b00, b[3:0], 2'b00};
            end
            if (is_v6) begin
                if (pos == CW'(20)) begin
                    proto_next = b;
                end
                if (pos >= CW'(22) && pos < CW'(54)) begin
                    addr_next[rel_v6[4:3]][8 * (3'd7 - rel_v6[2:0]) +: 8] = b;
                end
            end
            else begin
                if (pos == CW'(23)) begin
                    proto_next = b;
                end
                if (pos >= CW'(26) && pos < CW'(30)) begin
                    addr_next[1][8 * (5'd29 - pos[4:0]) +: 8] = b;
                end
                else if (pos >= CW'(30) && pos < CW'(34)) begin
                    addr_next[3][8 * (6'd33 - pos[5:0]) +: 8] = b;
                end
            end
            off_w  = PW'(l4off_next);
            rel_l4 = pos_w - off_w;
            if (pos_w >= off_w && rel_l4 < PW'(4)) begin
                l4_next[8 * (2'd3 - rel_l4[1:0]) +: 8] = b;
            end
        end
    end

    always_comb
    begin
        known  = (count_next >= CW'(14));
        need   = (ether_next == ETYPE_IPV6) ? 9'd54 : 9'd34;
        extra  = 9'd0;
        kind   = KIND_OTHER;
        if (proto_next == PROTO_TCP) begin
            kind  = KIND_TCP;
            extra = 9'd4;
        end
        else if (proto_next == PROTO_UDP) begin
            kind  = KIND_UDP;
            extra = 9'd4;
        end
        else if (proto_next == PROTO_ICMP || proto_next == PROTO_ICMP6) begin
            kind  = KIND_ICMP;
            extra = 9'd2;
        end
        l4_end = {1'b0, l4off_next} + extra;
        if (extra != 9'd0 && l4_end > need) begin
            need = l4_end;
        end
        if (PW'(count_next) < PW'(need)) begin
            kind = KIND_TRUNC;
        end
        if (known && ether_next == ETYPE_ARP) begin
            kind = (count_next >= CW'(42)) ? KIND_ARP : KIND_TRUNC;
        end
        if (!known) begin
            kind = KIND_TRUNC;
        end
        summary.kind      = kind;
        summary.v6        = known && (ether_next == ETYPE_IPV6);
        summary.length    = CNT_W'(count_next);
        summary.mac       = mac_next;
        summary.addr      = addr_next;
        summary.l4        = l4_next;
        summary.arp_fixed = arpfix_next;
        summary.arp_hw    = arphw_next;
        summary.arp_ip    = arpip_next;
        push              = accept && item.end_of_frame;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            count_reg  <= '0;
            ether_reg  <= '0;
            l4off_reg  <= '0;
            proto_reg  <= '0;
            mac_reg    <= '0;
            addr_reg   <= '0;
            l4_reg     <= '0;
            arpfix_reg <= '0;
            arphw_reg  <= '0;
            arpip_reg  <= '0;
        end
        else if (accept) begin
            if (item.end_of_frame) begin
                count_reg  <= '0;
                ether_reg  <= '0;
                l4off_reg  <= '0;
                proto_reg  <= '0;
                mac_reg    <= '0;
                addr_reg   <= '0;
                l4_reg     <= '0;
                arpfix_reg <= '0;
                arphw_reg  <= '0;
                arpip_reg  <= '0;
            end
            else begin
                count_reg  <= count_next;
                ether_reg  <= ether_next;
                l4off_reg  <= l4off_next;
                proto_reg  <= proto_next;
                mac_reg    <= mac_next;
                addr_reg   <= addr_next;
                l4_reg     <= l4_next;
                arpfix_reg <= arpfix_next;
                arphw_reg  <= arphw_next;
                arpip_reg  <= arpip_next;
            end
        end
    end

endmodule

// ===== hdl/ehx_queue.sv =====
module ehx_queue
    import ehx_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  summary_t push_data,
    output logic     full,
    input  logic     pop,
    output logic     head_valid,
    output summary_t head
);

    localparam int AW = $clog2(QUEUE_DEPTH);

    summary_t      mem [QUEUE_DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [AW:0]   cnt_reg, cnt_next;
    logic          do_pop;

    assign full       = (cnt_reg == (AW + 1)'(QUEUE_DEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head       = mem[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (push && !do_pop) begin
            cnt_next = cnt_reg + (AW + 1)'(1);
        end
        else if (!push && do_pop) begin
            cnt_next = cnt_reg - (AW + 1)'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

`ifndef ASSERT_OFF
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= (AW + 1)'(QUEUE_DEPTH))
        else $error("queue occupancy exceeds its depth");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("frame summary written into a full queue");
`endif

endmodule

// ===== hdl/ehx_back.sv =====
module ehx_back
    import ehx_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     head_valid,
    input  summary_t head,
    output logic     pop,
    output logic     rec_valid,
    input  logic     rec_stall,
    output record_t  rec_data
);

    logic [2:0]  idx_reg, idx_next;
    logic        valid_reg, valid_next;
    record_t     data_reg, data_next;
    logic        load;
    logic        last;
    logic [3:0]  tag;
    logic [63:0] value;

    assign load = head_valid && (!valid_reg || !rec_stall);
    assign last = rec_last(head.kind, idx_reg);
    assign tag  = rec_tag(head.kind, idx_reg);
    assign pop  = load && last;

    always_comb
    begin
        unique case (tag)
            TAG_DST_MAC:   value = {16'd0, head.mac[0]};
            TAG_SRC_MAC:   value = {16'd0, head.mac[1]};
            TAG_LENGTH:    value = 64'(head.length);
            TAG_SRC_IP_HI: value = head.addr[0];
            TAG_SRC_IP_LO: value = head.addr[1];
            TAG_DST_IP_HI: value = head.addr[2];
            TAG_DST_IP_LO: value = head.addr[3];
            TAG_PORTS:     value = {32'd0, head.l4};
            TAG_ICMP:      value = {48'd0, head.l4[31:16]};
            TAG_ARP_FIXED: value = head.arp_fixed;
            TAG_ARP_SHA:   value = {16'd0, head.arp_hw[0]};
            TAG_ARP_SPA:   value = {32'd0, head.arp_ip[0]};
            TAG_ARP_THA:   value = {16'd0, head.arp_hw[1]};
            TAG_ARP_TPA:   value = {32'd0, head.arp_ip[1]};
            default:       value = '0;
        endcase
    end

    always_comb
    begin
        idx_next   = idx_reg;
        data_next  = data_reg;
        valid_next = valid_reg && rec_stall;
        if (load)
        begin
            valid_next            = 1'b1;
            data_next.frame_kind  = head.kind;
            data_next.over_ipv6   = head.v6;
            data_next.field_tag   = tag;
            data_next.field_value = value;
            data_next.last_record = last;
            idx_next              = last ? 3'd0 : idx_reg + 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign rec_valid = valid_reg;
    assign rec_data  = data_reg;

`ifndef ASSERT_OFF
    a_idx_restart: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> idx_reg == 3'd0)
        else $error("record index did not restart after the last record");

    a_idx_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !head_valid |-> idx_reg == 3'd0)
        else $error("record index left mid-run with no frame queued");
`endif

endmodule

// ===== hdl/ethernet_l3_l4_header_extractor_unit.sv =====
// The unit takes one frame byte per cycle and never stalls the byte stream while fewer than
// two finished frames wait for their records to be taken. At the final byte of a frame a
// summary enters a two-entry queue, and the back end emits that frame's records one per
// cycle while rec_stall is low, from an output register, three to eight records a frame.
// When the back end is idle, the first record passes from the queue entry into the output
// register and is presented from there. Input stall is raised only when the queue is full.
module ethernet_l3_l4_header_extractor_unit
    import ehx_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = 65535
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    byte_valid,
    output logic    byte_stall,
    input  byte_t   byte_data,
    output logic    rec_valid,
    input  logic    rec_stall,
    output record_t rec_data
);

    logic     accept;
    logic     push;
    logic     full;
    logic     pop;
    logic     head_valid;
    summary_t summary;
    summary_t head;

    assign byte_stall = full;
    assign accept     = byte_valid && !full;

    ehx_front #(
        .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (byte_data),
        .push   (push),
        .summary(summary)
    );

    ehx_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (summary),
        .full      (full),
        .pop       (pop),
        .head_valid(head_valid),
        .head      (head)
    );

    ehx_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_valid(head_valid),
        .head      (head),
        .pop       (pop),
        .rec_valid (rec_valid),
        .rec_stall (rec_stall),
        .rec_data  (rec_data)
    );

endmodule
